// ===== design/tbt_pkg.sv =====
// Shared constants for the thermistor beta temperature block.
// Field widths, fixed-point constants, status codes and register indexes.
// No dependencies.
package tbt_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TEMP_W     = 18;
    localparam int STATUS_W   = 2;
    localparam int REF_TEMP_W = 15;
    localparam int RES_W      = 20;
    localparam int BETA_W     = 14;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam int DEF_AVG_DEPTH      = 8;
    localparam int DEF_ADC_FULL_SCALE = 1023;

    localparam int FRAC_BITS = 24;
    localparam int M_W       = 31;
    localparam int MUL_W     = 32;
    localparam int K0_W      = 16;
    localparam int B100_W    = 21;

    localparam logic [MUL_W-1:0] LN2_Q32 = 32'd2977044472;
    localparam int ABS_ZERO_CENTI = 27315;
    localparam int TEMP_MAX_CENTI = 99999;

    localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOW   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HIGH  = 2'd2;

    localparam logic [1:0] REG_REF_TEMP = 2'd0;
    localparam logic [1:0] REG_REF_RES  = 2'd1;
    localparam logic [1:0] REG_DIV_RES  = 2'd2;
    localparam logic [1:0] REG_BETA     = 2'd3;

    localparam logic [REF_TEMP_W-1:0] RST_REF_TEMP = 15'd2500;
    localparam logic [RES_W-1:0]      RST_REF_RES  = 20'd10000;
    localparam logic [RES_W-1:0]      RST_DIV_RES  = 20'd10000;
    localparam logic [BETA_W-1:0]     RST_BETA     = 14'd4200;

endpackage

// ===== design/tbt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/thermistor_beta_temperature.sv =====
// Top level of the NTC thermistor temperature block: moving average, log2 by
// squaring, beta equation and restoring division, all under one sequencer.
// Depends on tbt_pkg and tbt_ram.
//
//  Channel   Ports                                   Direction  Beat carries
//  s_        s_valid s_ready s_sample                in         one raw ADC sample
//  m_        m_valid m_ready m_temp_centi m_status   out        temperature and status
//  apb       psel penable pwrite paddr pwdata ...    in/out     register write or read
//
// Each sample passes through two bit-serial log2 normalizations, the 24 squaring
// steps of each log2 on the shared multiplier, and the one-bit-a-cycle divider;
// out-of-range averages skip straight to the result. The first sample after
// reset first fills every entry of the ring with its own value.
// Reset is synchronous and active low. s_ready is high only while the sequencer
// is idle; a finished result waits in the output register while the next
// sample is taken, and the sequencer holds its last step if that register is full.
module thermistor_beta_temperature
    import tbt_pkg::*;
#(
    parameter int AVG_DEPTH      = DEF_AVG_DEPTH,
    parameter int ADC_FULL_SCALE = DEF_ADC_FULL_SCALE
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_W-1:0]        s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [TEMP_W-1:0]   m_temp_centi,
    output logic [STATUS_W-1:0]        m_status,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    // Widths follow from the parameters so that every product and the
    // dividend fit without loss.
    localparam int AW     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W  = $clog2(((1 << SAMPLE_W) - 1) * AVG_DEPTH + 1);
    localparam int FULL_W = $clog2(ADC_FULL_SCALE * AVG_DEPTH + 1);
    localparam int OP_W   = (SUM_W > FULL_W) ? SUM_W : FULL_W;
    localparam int LOGW   = (RES_W + OP_W > M_W) ? RES_W + OP_W : M_W;
    localparam int P_W    = $clog2(LOGW);
    localparam int L_W    = P_W + FRAC_BITS;
    localparam int QK_W   = L_W + K0_W;
    localparam int BASE_W = B100_W + FRAC_BITS;
    localparam int DEN_W  = ((QK_W > BASE_W) ? QK_W : BASE_W) + 1;
    localparam int NUM_W  = B100_W + K0_W + FRAC_BITS;
    localparam int DVD_W  = NUM_W + 1;
    localparam int DC_W   = $clog2(DVD_W);
    localparam int SQ_W   = $clog2(FRAC_BITS);

    localparam logic [OP_W-1:0]  FULL_V   = OP_W'(ADC_FULL_SCALE * AVG_DEPTH);
    localparam logic [OP_W-1:0]  LOW_LIM  = OP_W'(10 * AVG_DEPTH);
    localparam logic [OP_W-1:0]  HIGH_LIM = OP_W'((ADC_FULL_SCALE - 10) * AVG_DEPTH);
    localparam logic [DVD_W-1:0] TK_MAX   = DVD_W'(TEMP_MAX_CENTI + ABS_ZERO_CENTI);
    localparam logic [AW-1:0]    LAST_IDX = AW'(AVG_DEPTH - 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_FILL = 5'd1;
    localparam logic [4:0] S_RD   = 5'd2;
    localparam logic [4:0] S_CHK  = 5'd3;
    localparam logic [4:0] S_NORM = 5'd4;
    localparam logic [4:0] S_SQ   = 5'd5;
    localparam logic [4:0] S_LOGB = 5'd6;
    localparam logic [4:0] S_LN   = 5'd7;
    localparam logic [4:0] S_Q    = 5'd8;
    localparam logic [4:0] S_QR   = 5'd9;
    localparam logic [4:0] S_QK   = 5'd10;
    localparam logic [4:0] S_DEN  = 5'd11;
    localparam logic [4:0] S_NUM  = 5'd12;
    localparam logic [4:0] S_DVD  = 5'd13;
    localparam logic [4:0] S_DIV  = 5'd14;
    localparam logic [4:0] S_TK   = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;

    logic [4:0] state_reg, state_next;

    // Configuration registers.
    logic signed [REF_TEMP_W-1:0] ref_temp_reg;
    logic [RES_W-1:0]             ref_res_reg;
    logic [RES_W-1:0]             div_res_reg;
    logic [BETA_W-1:0]            beta_reg;
    logic                         cfg_write;
    logic [1:0]                   cfg_index;

    // Moving-average state.
    logic [SAMPLE_W-1:0] sample_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       fill_reg;
    logic                first_pending_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Arithmetic state.
    logic [LOGW-1:0]      xw_reg;
    logic [P_W-1:0]       p_reg;
    logic [M_W-1:0]       m_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [SQ_W-1:0]      sq_cnt_reg;
    logic                 log_sel_reg;
    logic [L_W-1:0]       lnum_reg;
    logic [L_W-1:0]       mag_reg;
    logic                 neg_reg;
    logic [2*MUL_W-1:0]   prod_reg;
    logic [L_W-1:0]       q_reg;
    logic [QK_W-1:0]      qk_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DC_W-1:0]      div_cnt_reg;
    logic signed [TEMP_W-1:0] res_temp_reg;
    logic [STATUS_W-1:0]      res_status_reg;

    // Output register.
    logic                     m_valid_reg;
    logic signed [TEMP_W-1:0] m_temp_reg;
    logic [STATUS_W-1:0]      m_status_reg;

    // Operands with zero registers taken as one.
    logic [RES_W-1:0]       r0_eff, r1_eff;
    logic [BETA_W-1:0]      b_eff;
    logic [B100_W-1:0]      b100;
    logic [BASE_W-1:0]      base;
    logic signed [K0_W:0]   k0_s;
    logic [K0_W-1:0]        k0;
    logic [OP_W-1:0]        sum_ext;
    logic [OP_W-1:0]        rest;

    // Shared multiplier.
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic [M_W:0]       mm;

    logic [L_W-1:0]       lcur;
    logic [2*MUL_W-1:0]   qsum;
    logic [DEN_W:0]       trial;
    logic                 out_free;

    assign r0_eff  = (ref_res_reg == '0) ? RES_W'(1) : ref_res_reg;
    assign r1_eff  = (div_res_reg == '0) ? RES_W'(1) : div_res_reg;
    assign b_eff   = (beta_reg == '0) ? BETA_W'(1) : beta_reg;
    assign b100    = B100_W'(b_eff) * B100_W'(100);
    assign base    = {b100, FRAC_BITS'(0)};
    assign k0_s    = (K0_W+1)'(ref_temp_reg) + (K0_W+1)'(ABS_ZERO_CENTI);
    assign k0      = k0_s[K0_W-1:0];
    assign sum_ext = OP_W'(sum_reg);
    assign rest    = FULL_V - sum_ext;
    assign lcur    = {p_reg, frac_reg};
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CHK: begin
                mul_a = MUL_W'(r1_eff);
                mul_b = MUL_W'(sum_ext);
            end
            S_LOGB: begin
                mul_a = MUL_W'(r0_eff);
                mul_b = MUL_W'(rest);
            end
            S_SQ: begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            S_Q: begin
                mul_a = MUL_W'(mag_reg);
                mul_b = LN2_Q32;
            end
            S_QK: begin
                mul_a = MUL_W'(q_reg);
                mul_b = MUL_W'(k0);
            end
            S_NUM: begin
                mul_a = MUL_W'(b100);
                mul_b = MUL_W'(k0);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign mm    = mul_p[2*M_W-1:M_W-1];
    assign qsum  = prod_reg + (2*MUL_W)'(64'h8000_0000);
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};

    // Ring of samples.
    assign ram_we    = (state_reg == S_FILL) || (state_reg == S_RD);
    assign ram_waddr = (state_reg == S_FILL) ? fill_reg : ptr_reg;

    tbt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = first_pending_reg ? S_FILL : S_RD;
                end
            end
            S_FILL: begin
                if (fill_reg == LAST_IDX) begin
                    state_next = S_CHK;
                end
            end
            S_RD: state_next = S_CHK;
            S_CHK: begin
                if (sum_ext < LOW_LIM || sum_ext > HIGH_LIM) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                if (xw_reg[LOGW-1]) begin
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                if (sq_cnt_reg == SQ_W'(FRAC_BITS - 1)) begin
                    state_next = log_sel_reg ? S_LN : S_LOGB;
                end
            end
            S_LOGB: state_next = S_NORM;
            S_LN:   state_next = S_Q;
            S_Q:    state_next = S_QR;
            S_QR:   state_next = S_QK;
            S_QK:   state_next = S_DEN;
            S_DEN: begin
                if (neg_reg && DEN_W'(qk_reg) >= DEN_W'(base)) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_NUM;
                end
            end
            S_NUM: state_next = S_DVD;
            S_DVD: state_next = S_DIV;
            S_DIV: begin
                if (div_cnt_reg == DC_W'(DVD_W - 1)) begin
                    state_next = S_TK;
                end
            end
            S_TK: state_next = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            ptr_reg           <= '0;
            first_pending_reg <= 1'b1;
            sum_reg           <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FILL && fill_reg == LAST_IDX) begin
                sum_reg           <= SUM_W'(sample_reg) * SUM_W'(AVG_DEPTH);
                first_pending_reg <= 1'b0;
            end
            if (state_reg == S_RD) begin
                sum_reg <= sum_reg - SUM_W'(ram_rdata) + SUM_W'(sample_reg);
                ptr_reg <= (ptr_reg == LAST_IDX) ? '0 : ptr_reg + AW'(1);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                sample_reg <= s_sample;
                fill_reg   <= '0;
            end
            S_FILL: fill_reg <= fill_reg + AW'(1);
            S_CHK: begin
                if (sum_ext < LOW_LIM) begin
                    res_temp_reg   <= TEMP_W'(TEMP_MAX_CENTI);
                    res_status_reg <= STATUS_LOW;
                end else begin
                    res_temp_reg   <= -TEMP_W'(ABS_ZERO_CENTI);
                    res_status_reg <= STATUS_HIGH;
                end
                xw_reg      <= (mul_p[LOGW-1:0] == '0) ? LOGW'(1) : mul_p[LOGW-1:0];
                p_reg       <= P_W'(LOGW - 1);
                log_sel_reg <= 1'b0;
            end
            S_NORM: begin
                if (xw_reg[LOGW-1]) begin
                    m_reg      <= xw_reg[LOGW-1 -: M_W];
                    frac_reg   <= '0;
                    sq_cnt_reg <= '0;
                end else begin
                    xw_reg <= {xw_reg[LOGW-2:0], 1'b0};
                    p_reg  <= p_reg - P_W'(1);
                end
            end
            S_SQ: begin
                frac_reg   <= {frac_reg[FRAC_BITS-2:0], mm[M_W]};
                m_reg      <= mm[M_W] ? mm[M_W:1] : mm[M_W-1:0];
                sq_cnt_reg <= sq_cnt_reg + SQ_W'(1);
            end
            S_LOGB: begin
                lnum_reg    <= lcur;
                xw_reg      <= (mul_p[LOGW-1:0] == '0) ? LOGW'(1) : mul_p[LOGW-1:0];
                p_reg       <= P_W'(LOGW - 1);
                log_sel_reg <= 1'b1;
            end
            S_LN: begin
                neg_reg <= lcur > lnum_reg;
                mag_reg <= (lcur > lnum_reg) ? lcur - lnum_reg : lnum_reg - lcur;
            end
            S_Q:  prod_reg <= mul_p;
            S_QR: q_reg <= qsum[MUL_W +: L_W];
            S_QK: qk_reg <= mul_p[QK_W-1:0];
            S_DEN: begin
                res_temp_reg   <= TEMP_W'(TEMP_MAX_CENTI);
                res_status_reg <= STATUS_VALID;
                den_reg <= neg_reg ? DEN_W'(base) - DEN_W'(qk_reg)
                                   : DEN_W'(base) + DEN_W'(qk_reg);
            end
            S_NUM: prod_reg <= mul_p;
            S_DVD: begin
                dvd_reg <= DVD_W'({prod_reg[NUM_W-FRAC_BITS-1:0], FRAC_BITS'(0)})
                         + DVD_W'(den_reg >> 1);
                rem_reg     <= '0;
                quo_reg     <= '0;
                div_cnt_reg <= '0;
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                    quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[DEN_W-1:0];
                    quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
                end
                dvd_reg     <= {dvd_reg[DVD_W-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + DC_W'(1);
            end
            S_TK: begin
                if (quo_reg > TK_MAX) begin
                    res_temp_reg <= TEMP_W'(TEMP_MAX_CENTI);
                end else begin
                    res_temp_reg <= quo_reg[TEMP_W-1:0] - TEMP_W'(ABS_ZERO_CENTI);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register. A new result may replace one that leaves in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= (state_reg == S_FIN && out_free) ? 1'b1
                         : (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            m_temp_reg   <= res_temp_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_temp_centi = m_temp_reg;
    assign m_status     = m_status_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_temp_reg <= RST_REF_TEMP;
            ref_res_reg  <= RST_REF_RES;
            div_res_reg  <= RST_DIV_RES;
            beta_reg     <= RST_BETA;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_REF_TEMP: ref_temp_reg <= pwdata[REF_TEMP_W-1:0];
                REG_REF_RES:  ref_res_reg  <= pwdata[RES_W-1:0];
                REG_DIV_RES:  div_res_reg  <= pwdata[RES_W-1:0];
                REG_BETA:     beta_reg     <= pwdata[BETA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_REF_TEMP: prdata = PDATA_W'(signed'(ref_temp_reg));
            REG_REF_RES:  prdata = PDATA_W'(ref_res_reg);
            REG_DIV_RES:  prdata = PDATA_W'(div_res_reg);
            REG_BETA:     prdata = PDATA_W'(beta_reg);
            default:      prdata = '0;
        endcase
    end

    // A sample beat is never followed directly by another one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample accepted while busy");

    // The squaring loop keeps its mantissa normalized.
    a_mant_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQ) |-> m_reg[M_W-1])
        else $error("log2 mantissa lost its leading one");

    // The ring is only swept while the first sample is pending.
    a_fill_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> first_pending_reg)
        else $error("ring fill outside the first sample");

    // Under-range results always carry absolute zero.
    a_high_abs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_HIGH) |-> (m_temp_centi == -TEMP_W'(ABS_ZERO_CENTI)))
        else $error("under-range result without absolute zero");

    // Status never takes the unused code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_VALID || m_status == STATUS_LOW
                     || m_status == STATUS_HIGH))
        else $error("undefined status code");

endmodule
